/* hw/rtl/rnts_pkg.sv */
package rnts_pkg;

  localparam int unsigned AlphabetSizeDefault = 32;
  localparam int unsigned ValueWidthDefault   = 32;

  localparam int unsigned ValueInW    = 32;
  localparam int unsigned SymbolW     = 8;
  localparam int unsigned NumSymbols  = 32;
  localparam int unsigned SymIdxW     = 5;
  localparam int unsigned AlphaWords  = 4;
  localparam int unsigned AlphaWordW  = 64;
  localparam int unsigned BaseSizeW   = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgBaseSize  = cfg_idx_t'(0);
  localparam cfg_idx_t CfgAlphabet0 = cfg_idx_t'(1);
  localparam cfg_idx_t CfgAlphabet1 = cfg_idx_t'(2);
  localparam cfg_idx_t CfgAlphabet2 = cfg_idx_t'(3);
  localparam cfg_idx_t CfgAlphabet3 = cfg_idx_t'(4);

  localparam logic [SymbolW-1:0] SymMinus   = 8'h2D;
  localparam logic [SymbolW-1:0] SymPlus    = 8'h2B;
  localparam logic [SymbolW-1:0] SymTab     = 8'h09;
  localparam logic [SymbolW-1:0] SymNewline = 8'h0A;
  localparam logic [SymbolW-1:0] SymSpace   = 8'h20;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  function automatic logic is_forbidden(input logic [SymbolW-1:0] s);
    return (s == SymPlus) || (s == SymMinus) || (s == SymTab) ||
           (s == SymNewline) || (s == SymSpace);
  endfunction

endpackage

/* hw/rtl/radix_number_to_symbols.sv */
// conversion: an accepted value is converted bit-serially, one input bit per cycle shifted
// through the digit cells; the symbols then pass through the output register, which the
// receiver can stall.
// throughput: one symbol per cycle while the receiver is ready; a new value is accepted only
// once the previous one has emitted its last symbol or been found invalid.
// reset: control state, base size and alphabet clear to zero; no clearing pass.
module radix_number_to_symbols #(
  parameter int unsigned ALPHABET_SIZE = rnts_pkg::AlphabetSizeDefault,
  parameter int unsigned VALUE_WIDTH   = rnts_pkg::ValueWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rnts_pkg::ValueInW-1:0]  value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [rnts_pkg::SymbolW-1:0]   symbol_o,
  output logic                                  last_o,
  input  logic                                  cfg_we_i,
  input  logic        [rnts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [rnts_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned DigitW     = $clog2(ALPHABET_SIZE);
  localparam int unsigned RadixW     = DigitW + 1;
  localparam int unsigned NumDigits  = VALUE_WIDTH;
  localparam int unsigned IdxW       = $clog2(NumDigits);
  localparam int unsigned NdW        = $clog2(NumDigits + 1);
  localparam int unsigned ConvCycles = (VALUE_WIDTH > ALPHABET_SIZE) ? VALUE_WIDTH
                                                                     : ALPHABET_SIZE;
  localparam int unsigned CntW       = $clog2(ConvCycles);
  localparam logic [CntW-1:0] LastCnt = CntW'(ConvCycles - 1);

  rnts_pkg::state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   bad_q, bad_d;
  logic [NdW-1:0]         ndig_q, ndig_d;
  logic [DigitW-1:0]      cells_q [NumDigits];
  logic [DigitW-1:0]      cells_d [NumDigits];
  logic                   sign_q, sign_d;
  logic [IdxW-1:0]        eidx_q, eidx_d;

  logic                            out_valid_q, out_valid_d;
  logic [rnts_pkg::SymbolW-1:0]    symbol_q, symbol_d;
  logic                            last_q, last_d;

  logic [rnts_pkg::BaseSizeW-1:0]  base_size_q;
  logic [rnts_pkg::AlphaWordW-1:0] alpha_q [rnts_pkg::AlphaWords];
  logic [rnts_pkg::SymbolW-1:0]    sym [rnts_pkg::NumSymbols];

  logic                            in_xfer;
  logic                            load_out;
  logic                            conv_done;
  logic                            shift_en;
  logic [RadixW-1:0]               radix;
  logic [NumDigits-1:0]            co0, co1;
  logic [NumDigits:0]              csum, carry;
  logic [rnts_pkg::SymIdxW-1:0]    rd_idx;
  logic [rnts_pkg::SymbolW-1:0]    rd_sym;
  logic                            dup;
  logic                            chk_hit;
  logic [VALUE_WIDTH-1:0]          v_in;

  // alphabet bytes, lowest byte of each word first
  for (genvar g = 0; g < rnts_pkg::NumSymbols; g++) begin : g_sym
    assign sym[g] = alpha_q[g >> 3][(g & 7) * 8 +: 8];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q <= '0;
      for (int k = 0; k < rnts_pkg::AlphaWords; k++) begin
        alpha_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rnts_pkg::CfgBaseSize:  base_size_q <= cfg_wdata_i[rnts_pkg::BaseSizeW-1:0];
        rnts_pkg::CfgAlphabet0: alpha_q[0]  <= cfg_wdata_i;
        rnts_pkg::CfgAlphabet1: alpha_q[1]  <= cfg_wdata_i;
        rnts_pkg::CfgAlphabet2: alpha_q[2]  <= cfg_wdata_i;
        rnts_pkg::CfgAlphabet3: alpha_q[3]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rnts_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = rnts_pkg::StConv;
        end
      end
      rnts_pkg::StConv: begin
        if (conv_done) begin
          state_d = bad_d ? rnts_pkg::StIdle : rnts_pkg::StEmit;
        end
      end
      rnts_pkg::StEmit: begin
        if (load_out && !sign_q && (eidx_q == '0)) begin
          state_d = rnts_pkg::StIdle;
        end
      end
      default: state_d = rnts_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = (state_q == rnts_pkg::StIdle);
    in_xfer    = in_valid_i && in_ready_o;
    conv_done  = (state_q == rnts_pkg::StConv) && (cnt_q == LastCnt);
    shift_en   = (state_q == rnts_pkg::StConv) &&
                 ({1'b0, cnt_q} < (CntW + 1)'(VALUE_WIDTH));
    load_out   = (state_q == rnts_pkg::StEmit) && (!out_valid_q || out_ready_i);
  end

  // digit cells: doubling plus the incoming bit, with a carry wherever 2d+c reaches the radix.
  // a cell's carry out is fixed (co0), killed (!co1) or passed on, so an adder resolves the chain
  always_comb begin
    radix = base_size_q[RadixW-1:0];
    for (int i = 0; i < NumDigits; i++) begin
      co0[i] = ({cells_q[i], 1'b0} >= radix);
      co1[i] = ({cells_q[i], 1'b1} >= radix);
    end
    csum  = {1'b0, co0} + {1'b0, co1} + (NumDigits + 1)'(mag_q[VALUE_WIDTH-1]);
    carry = csum ^ {1'b0, co0} ^ {1'b0, co1};
  end

  // one shared alphabet read: symbol under check while converting, digit symbol while emitting
  always_comb begin
    rd_idx = (state_q == rnts_pkg::StConv) ? rnts_pkg::SymIdxW'(cnt_q)
                                           : rnts_pkg::SymIdxW'(cells_q[eidx_q]);
    rd_sym = sym[rd_idx];
    dup    = 1'b0;
    for (int j = 0; j < rnts_pkg::NumSymbols; j++) begin
      if ((rnts_pkg::SymIdxW'(j) < rd_idx) && (sym[j] == rd_sym)) begin
        dup = 1'b1;
      end
    end
    chk_hit = (state_q == rnts_pkg::StConv) &&
              ({1'b0, rd_idx} < base_size_q) &&
              (rnts_pkg::is_forbidden(rd_sym) || dup);
  end

  // conversion and emit bookkeeping
  always_comb begin
    v_in   = value_i[VALUE_WIDTH-1:0];
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    bad_d  = bad_q;
    ndig_d = ndig_q;
    sign_d = sign_q;
    eidx_d = eidx_q;
    for (int i = 0; i < NumDigits; i++) begin
      cells_d[i] = cells_q[i];
    end
    if (in_xfer) begin
      cnt_d  = '0;
      mag_d  = v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;
      sign_d = v_in[VALUE_WIDTH-1];
      bad_d  = (base_size_q < rnts_pkg::BaseSizeW'(2)) ||
               (base_size_q > rnts_pkg::BaseSizeW'(ALPHABET_SIZE));
      ndig_d = '0;
      for (int i = 0; i < NumDigits; i++) begin
        cells_d[i] = '0;
      end
    end else if (state_q == rnts_pkg::StConv) begin
      cnt_d = cnt_q + 1'b1;
      if (shift_en) begin
        for (int i = 0; i < NumDigits; i++) begin
          cells_d[i] = DigitW'({cells_q[i], carry[i]} - (carry[i+1] ? radix : '0));
        end
        mag_d = mag_q << 1;
        // a carry into the first unused cell opens a new digit
        if (carry[ndig_q]) begin
          ndig_d = ndig_q + 1'b1;
        end
      end
      if (chk_hit) begin
        bad_d = 1'b1;
      end
      if (conv_done) begin
        eidx_d = (ndig_d == '0) ? '0 : IdxW'(ndig_d - 1'b1);
      end
    end else if (load_out) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        eidx_d = eidx_q - 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    symbol_d    = symbol_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      symbol_d    = sign_q ? rnts_pkg::SymMinus : rd_sym;
      last_d      = !sign_q && (eidx_q == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rnts_pkg::StIdle;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      ndig_q      <= '0;
      sign_q      <= 1'b0;
      eidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      ndig_q      <= ndig_d;
      sign_q      <= sign_d;
      eidx_q      <= eidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
    for (int i = 0; i < NumDigits; i++) begin
      cells_q[i] <= cells_d[i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  a_no_emit_when_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rnts_pkg::StEmit) |-> !bad_q)
    else $error("emitting with an invalid alphabet");

  a_emit_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rnts_pkg::StEmit) |->
      ((NdW'(eidx_q) < ndig_q) || ((ndig_q == '0) && (eidx_q == '0))))
    else $error("emit index beyond the converted digits");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == rnts_pkg::StConv) && (cnt_q == '0) && (ndig_q == '0))
    else $error("conversion did not start cleanly after a transfer");

  a_run_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rnts_pkg::StEmit) && (state_d == rnts_pkg::StIdle)) |=>
      (out_valid_q && last_q))
    else $error("symbol run ended without last");

endmodule

/* sim/radix_number_to_symbols_tb.sv */
`timescale 1ns / 1ps

module radix_number_to_symbols_tb;

  localparam int unsigned ValueW       = rnts_pkg::ValueWidthDefault;
  localparam int unsigned AlphaSize    = rnts_pkg::AlphabetSizeDefault;
  // bit-serial conversion plus the longest symbol run
  localparam int unsigned ItemCycles   = 1 + ValueW + ValueW + 1;
  localparam int unsigned SettleCycles = 2 * ItemCycles;
  localparam int unsigned WantBytes    = 12;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 25;

  localparam logic [rnts_pkg::AlphaWordW-1:0] Alpha0Dec = 64'h3736_3534_3332_3130;  // "01234567"
  localparam logic [rnts_pkg::AlphaWordW-1:0] Alpha1Hex = 64'h4645_4443_4241_3938;  // "89ABCDEF"
  localparam logic [rnts_pkg::AlphaWordW-1:0] Alpha2Odd = 64'h082E_2C01_7F80_FF00;
  localparam logic [rnts_pkg::AlphaWordW-1:0] Alpha3Ok  = 64'h4E4D_4C4B_4A49_4847;  // "GHIJKLMN"

  localparam logic [rnts_pkg::SymbolW-1:0] Banned [5] = '{
    rnts_pkg::SymPlus, rnts_pkg::SymMinus, rnts_pkg::SymTab,
    rnts_pkg::SymNewline, rnts_pkg::SymSpace
  };

  typedef struct packed {
    logic [rnts_pkg::SymbolW-1:0] symbol;
    logic                         last;
  } sym_beat_t;

  typedef enum logic {
    RowCfg,
    RowItem
  } row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    rnts_pkg::cfg_idx_t                 idx;
    logic [rnts_pkg::CfgDataW-1:0]      data;
    logic [rnts_pkg::ValueInW-1:0]      value;
    logic                               typed;
    logic [WantBytes*8-1:0]             want;
  } dir_row_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [rnts_pkg::ValueInW-1:0] value_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [rnts_pkg::SymbolW-1:0]         symbol_o;
  logic                                 last_o;
  logic                                 cfg_we_i;
  logic [rnts_pkg::CfgIdxW-1:0]         cfg_index_i;
  logic [rnts_pkg::CfgDataW-1:0]        cfg_wdata_i;

  radix_number_to_symbols u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // mirror of the configuration registers
  logic [rnts_pkg::BaseSizeW-1:0]  cur_base;
  logic [rnts_pkg::AlphaWordW-1:0] cur_alpha [rnts_pkg::AlphaWords];

  sym_beat_t   pending_symbols [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          tx_idle_on = 1'b1;
  logic [31:0] rx_pattern = '0;
  logic [4:0]  rx_pos     = '0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [rnts_pkg::SymbolW-1:0] symbol_at(
      input logic [rnts_pkg::SymIdxW-1:0] idx);
    return cur_alpha[idx[4:3]][idx[2:0]*8 +: 8];
  endfunction

  function automatic bit banned_symbol(input logic [rnts_pkg::SymbolW-1:0] s);
    foreach (Banned[k]) begin
      if (s == Banned[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit alphabet_ok();
    if (cur_base < 2 || cur_base > AlphaSize) return 1'b0;
    for (int unsigned i = 0; i < cur_base; i++) begin
      if (banned_symbol(symbol_at(i[4:0]))) return 1'b0;
      for (int unsigned j = 0; j < i; j++) begin
        if (symbol_at(j[4:0]) == symbol_at(i[4:0])) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // digits come out low first, so they are stacked and emitted from the top
  function automatic void predict_symbols(input logic [rnts_pkg::ValueInW-1:0] v);
    logic [rnts_pkg::ValueInW-1:0] mag;
    logic [rnts_pkg::SymIdxW-1:0]  digits [$];
    logic [rnts_pkg::SymIdxW-1:0]  d;
    if (!alphabet_ok()) return;
    mag = v[ValueW-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(rnts_pkg::SymIdxW'(mag % cur_base));
      mag = mag / cur_base;
    end while (mag != 0 && digits.size() < ValueW);
    if (v[ValueW-1]) pending_symbols.push_back('{symbol: rnts_pkg::SymMinus, last: 1'b0});
    while (digits.size() != 0) begin
      d = digits.pop_front();
      pending_symbols.push_back('{symbol: symbol_at(d), last: digits.size() == 0});
    end
  endfunction

  function automatic dir_row_t cfg_row(input rnts_pkg::cfg_idx_t idx,
                                       input logic [rnts_pkg::CfgDataW-1:0] data);
    return '{kind: RowCfg, idx: idx, data: data, value: '0, typed: 1'b0, want: '0};
  endfunction

  function automatic dir_row_t item_row(input logic [rnts_pkg::ValueInW-1:0] v);
    return '{kind: RowItem, idx: rnts_pkg::CfgBaseSize, data: '0, value: v, typed: 1'b0,
             want: '0};
  endfunction

  function automatic dir_row_t item_want(input logic [rnts_pkg::ValueInW-1:0] v,
                                         input logic [WantBytes*8-1:0] want);
    return '{kind: RowItem, idx: rnts_pkg::CfgBaseSize, data: '0, value: v, typed: 1'b1,
             want: want};
  endfunction

  task automatic cfg_write(input rnts_pkg::cfg_idx_t idx,
                           input logic [rnts_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      rnts_pkg::CfgBaseSize:  cur_base     = data[rnts_pkg::BaseSizeW-1:0];
      rnts_pkg::CfgAlphabet0: cur_alpha[0] = data;
      rnts_pkg::CfgAlphabet1: cur_alpha[1] = data;
      rnts_pkg::CfgAlphabet2: cur_alpha[2] = data;
      rnts_pkg::CfgAlphabet3: cur_alpha[3] = data;
      default: ;
    endcase
  endtask

  task automatic send_value(input logic [rnts_pkg::ValueInW-1:0] v);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (tx_idle_on) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70) : $urandom_range(0, 3);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // an item with an invalid alphabet may still be in conversion after the last symbol
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_symbols.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic random_setting();
    logic [rnts_pkg::SymbolW-1:0]    syms [rnts_pkg::NumSymbols];
    bit                              taken [256];
    logic [rnts_pkg::SymbolW-1:0]    b;
    logic [rnts_pkg::AlphaWordW-1:0] word;
    logic [rnts_pkg::CfgDataW-1:0]   base_word;
    int unsigned                     n, i, j;
    foreach (taken[k]) taken[k] = 1'b0;
    case ($urandom_range(0, 3))
      0:       n = 2;
      1:       n = rnts_pkg::NumSymbols;
      default: n = $urandom_range(2, rnts_pkg::NumSymbols);
    endcase
    for (i = 0; i < rnts_pkg::NumSymbols; i++) begin
      if (i < n) begin
        do b = rnts_pkg::SymbolW'($urandom); while (taken[b] || banned_symbol(b));
        taken[b] = 1'b1;
        syms[i]  = b;
      end else begin
        syms[i] = rnts_pkg::SymbolW'($urandom);
      end
    end
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                  : $urandom_range(AlphaSize + 1, 2**rnts_pkg::BaseSizeW - 1);
      1: syms[$urandom_range(0, n - 1)] = Banned[$urandom_range(0, 4)];
      2: begin
        i = $urandom_range(1, n - 1);
        j = $urandom_range(0, i - 1);
        syms[i] = syms[j];
      end
      default: ;
    endcase
    for (i = 0; i < rnts_pkg::AlphaWords; i++) begin
      for (j = 0; j < 8; j++) word[j*8 +: 8] = syms[i*8 + j];
      cfg_write(rnts_pkg::cfg_idx_t'(rnts_pkg::CfgAlphabet0 + i), word);
    end
    base_word = {$urandom, $urandom};
    base_word[rnts_pkg::BaseSizeW-1:0] = n[rnts_pkg::BaseSizeW-1:0];
    cfg_write(rnts_pkg::CfgBaseSize, base_word);
  endtask

  // receiver stall pattern, reloaded whenever the 5-bit rx_pos wraps to zero
  always @(negedge clk_i) begin
    if (rx_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern = '1;
        1:       rx_pattern = $urandom;
        2:       rx_pattern = $urandom & $urandom;
        default: rx_pattern = $urandom | $urandom;
      endcase
    end
    out_ready_i <= rx_pattern[rx_pos];
    rx_pos = rx_pos + 1'b1;
  end

  always @(posedge clk_i) begin
    sym_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_symbols.size() == 0) begin
        $error("symbol %h transfer with no symbol pending", symbol_o);
        fail_count++;
      end else begin
        exp_beat = pending_symbols.pop_front();
        if (symbol_o !== exp_beat.symbol) begin
          $error("symbol: expected %h, got %h", exp_beat.symbol, symbol_o);
          fail_count++;
        end
        if (last_o !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t                      dir_tab [$];
    dir_row_t                      row;
    logic [rnts_pkg::SymbolW-1:0]  ch;
    logic [rnts_pkg::ValueInW-1:0] v;
    bit                            started;
    bit                            was_item;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = rnts_pkg::CfgBaseSize;
    cfg_wdata_i = '0;
    cur_base    = '0;
    foreach (cur_alpha[k]) cur_alpha[k] = '0;

    dir_tab = '{
      item_want(32'd5, ""),                    // reset alphabet is empty
      cfg_row(rnts_pkg::CfgBaseSize, 64'd2),
      cfg_row(rnts_pkg::CfgAlphabet0, Alpha0Dec),
      item_want(32'd0, "0"),
      item_want(32'hFFFF_FFFF, "-1"),
      item_row(32'h7FFF_FFFF),
      item_row(32'h8000_0000),
      cfg_row(rnts_pkg::CfgAlphabet1, Alpha1Hex),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd10),
      item_want(32'd0, "0"),
      item_want(32'h7FFF_FFFF, "2147483647"),
      item_want(32'h8000_0000, "-2147483648"),
      item_want(-32'sd10, "-10"),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd16),
      item_want(32'hFFFF_FFFF, "-1"),
      item_want(32'h7FFF_FFFF, "7FFFFFFF"),
      item_want(32'h8000_0000, "-80000000"),
      item_want(32'hDEAD_BEEF, "-21524111"),
      cfg_row(rnts_pkg::CfgAlphabet2, Alpha2Odd),
      cfg_row(rnts_pkg::CfgAlphabet3, Alpha3Ok),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd32),
      item_row(32'h8000_0000),
      item_row(32'h7FFF_FFFF),
      item_row(32'h2B49_CA30),                 // digits 16..21, incl. zero byte symbol
      cfg_row(rnts_pkg::CfgBaseSize, 64'd1),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd33),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd63),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgBaseSize, 64'd32),
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha3Ok[63:8], rnts_pkg::SymPlus}),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha3Ok[63:8], rnts_pkg::SymMinus}),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha3Ok[63:8], rnts_pkg::SymTab}),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha3Ok[63:8], rnts_pkg::SymNewline}),
      item_want(32'd1, ""),
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha3Ok[63:8], rnts_pkg::SymSpace}),
      item_want(32'd1, ""),
      // last symbol repeats the first one, far from adjacent
      cfg_row(rnts_pkg::CfgAlphabet3, {Alpha0Dec[7:0], Alpha3Ok[55:0]}),
      item_want(32'd1, "")
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    was_item = 1'b0;
    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      if (row.kind == RowCfg) begin
        if (was_item) settle();
        cfg_write(row.idx, row.data);
        was_item = 1'b0;
      end else begin
        if (row.typed) begin
          started = 1'b0;
          for (int b = WantBytes - 1; b >= 0; b--) begin
            ch = row.want[b*8 +: 8];
            if (ch != 0) started = 1'b1;
            if (started) pending_symbols.push_back('{symbol: ch, last: b == 0});
          end
        end else begin
          predict_symbols(row.value);
        end
        send_value(row.value);
        was_item = 1'b1;
      end
    end
    settle();

    for (int p = 0; p < RandPhases; p++) begin
      random_setting();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (PhaseItems) begin
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 4))
              0:       v = '0;
              1:       v = '1;
              2:       v = 32'h7FFF_FFFF;
              3:       v = 32'h8000_0000;
              default: v = 32'd1;
            endcase
          end
          1, 2:    v = $urandom_range(0, 600) - 300;
          default: v = $urandom;
        endcase
        predict_symbols(v);
        send_value(v);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
